// ----- rtl/core/dna_primer_validator_defines.svh -----
// Assertion helpers shared by the primer validator RTL.
// Each expects clk and arst_n in scope.
`ifndef DNA_PRIMER_VALIDATOR_DEFINES_SVH
`define DNA_PRIMER_VALIDATOR_DEFINES_SVH

// Same-cycle implication.
`define DPV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DPV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dpv_pkg.sv -----
package dpv_pkg;

	localparam logic [7:0] ASCII_A = 8'h41;
	localparam logic [7:0] ASCII_C = 8'h43;
	localparam logic [7:0] ASCII_G = 8'h47;
	localparam logic [7:0] ASCII_T = 8'h54;

	localparam logic [2:0] REASON_NONE    = 3'd0;
	localparam logic [2:0] REASON_START   = 3'd1;
	localparam logic [2:0] REASON_LENGTH  = 3'd2;
	localparam logic [2:0] REASON_TEMP    = 3'd3;
	localparam logic [2:0] REASON_CONTENT = 3'd4;

	localparam logic [2:0] REG_LENGTH_MIN  = 3'd0;
	localparam logic [2:0] REG_LENGTH_MAX  = 3'd1;
	localparam logic [2:0] REG_TEMP_MIN    = 3'd2;
	localparam logic [2:0] REG_TEMP_MAX    = 3'd3;
	localparam logic [2:0] REG_CONTENT_MIN = 3'd4;
	localparam logic [2:0] REG_CONTENT_MAX = 3'd5;
	localparam logic [2:0] REG_GC_START    = 3'd6;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [11:0] length_min;
		logic [11:0] length_max;
		logic [13:0] temp_min;
		logic [13:0] temp_max;
		logic [16:0] content_min;
		logic [16:0] content_max;
		logic        require_gc_start;
	} dpv_cfg_t;

	typedef struct packed {
		logic        passed;
		logic [2:0]  fail_reason;
		logic [13:0] melt_temp;
		logic [11:0] gc_total;
		logic [11:0] primer_length;
	} dpv_result_t;

endpackage

// ----- rtl/core/dpv_fifo.sv -----
`include "dna_primer_validator_defines.svh"

module dpv_fifo #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`DPV_ASSERT_SAME(a_fifo_bound, 1'b1, count_q <= CW'(DEPTH), "queue count overflow")

endmodule

// ----- rtl/core/dpv_front.sv -----
`include "dna_primer_validator_defines.svh"

module dpv_front #(
	parameter int COUNT_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [7:0]                symbol,
	input  logic                      last_symbol,
	input  logic                      full,
	output logic                      rec_push,
	output logic [3*COUNT_BITS:0]     rec_data
);
	import dpv_pkg::*;

	logic [COUNT_BITS-1:0] len_q, at_q, gc_q;
	logic [COUNT_BITS-1:0] len_n, at_n, gc_n;
	logic                  start_q, start_n;
	logic                  is_gc, is_at, take;

	assign take  = push && !full;
	assign is_gc = (symbol == ASCII_G) || (symbol == ASCII_C);
	assign is_at = (symbol == ASCII_A) || (symbol == ASCII_T);

	always_comb begin
		len_n   = (len_q == '1) ? len_q : len_q + COUNT_BITS'(1);
		gc_n    = (is_gc && gc_q != '1) ? gc_q + COUNT_BITS'(1) : gc_q;
		at_n    = (is_at && at_q != '1) ? at_q + COUNT_BITS'(1) : at_q;
		start_n = (len_q == '0) ? is_gc : start_q;
	end

	// record carries the counts including the closing character
	assign rec_push = take && last_symbol;
	assign rec_data = {len_n, at_n, gc_n, start_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			at_q    <= '0;
			gc_q    <= '0;
			start_q <= 1'b0;
		end else if (take) begin
			if (last_symbol) begin
				len_q   <= '0;
				at_q    <= '0;
				gc_q    <= '0;
				start_q <= 1'b0;
			end else begin
				len_q   <= len_n;
				at_q    <= at_n;
				gc_q    <= gc_n;
				start_q <= start_n;
			end
		end
	end

	`DPV_ASSERT_NEXT(a_front_clear, rec_push, len_q == '0 && gc_q == '0 && at_q == '0, "counts not cleared after last symbol")

endmodule

// ----- rtl/core/dpv_back.sv -----
`include "dna_primer_validator_defines.svh"

module dpv_back #(
	parameter int COUNT_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpv_pkg::dpv_cfg_t         cfg,
	input  logic                      in_empty,
	input  logic [3*COUNT_BITS:0]     in_data,
	output logic                      in_pop,
	input  logic                      out_full,
	output logic                      out_push,
	output dpv_pkg::dpv_result_t      out_data
);
	import dpv_pkg::*;

	localparam int TW = COUNT_BITS + 3;
	localparam int PW = COUNT_BITS + 17;

	logic [COUNT_BITS-1:0] len_in, at_in, gc_in;
	logic                  start_in;
	logic [TW-1:0]         temp_in;

	logic                  v_s1, v_s2;
	logic                  adv_s1, adv_s2;
	logic                  start_fail_s1, len_fail_s1, temp_fail_s1, cmax_zero_s1;
	logic [PW-1:0]         pmin_s1, pmax_s1, gcs_s1;
	logic [TW-1:0]         temp_s1;
	logic [COUNT_BITS-1:0] len_s1, gc_s1;
	dpv_result_t           res_s2;
	logic                  gc_fail;
	logic [2:0]            reason;

	assign {len_in, at_in, gc_in, start_in} = in_data;
	assign temp_in = (TW'(at_in) << 1) + (TW'(gc_in) << 2);

	assign adv_s2   = !v_s2 || !out_full;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_pop   = !in_empty && adv_s1;
	assign out_push = v_s2;
	assign out_data = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= !in_empty;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1: bound checks and cross products for the GC fraction
	always_ff @(posedge clk) begin
		if (in_pop) begin
			start_fail_s1 <= cfg.require_gc_start && !start_in;
			len_fail_s1   <= !(cfg.length_max != '0
				&& 32'(len_in) >= 32'(cfg.length_min)
				&& 32'(len_in) <= 32'(cfg.length_max));
			temp_fail_s1  <= !(cfg.temp_max != '0
				&& 32'(temp_in) >= 32'(cfg.temp_min)
				&& 32'(temp_in) <= 32'(cfg.temp_max));
			cmax_zero_s1  <= (cfg.content_max == '0);
			pmin_s1       <= PW'(cfg.content_min) * PW'(len_in);
			pmax_s1       <= PW'(cfg.content_max) * PW'(len_in);
			gcs_s1        <= PW'(gc_in) << 16;
			temp_s1       <= temp_in;
			len_s1        <= len_in;
			gc_s1         <= gc_in;
		end
	end

	assign gc_fail = cmax_zero_s1 || (gcs_s1 < pmin_s1) || (gcs_s1 > pmax_s1);

	always_comb begin
		priority if (start_fail_s1) begin
			reason = REASON_START;
		end else if (len_fail_s1) begin
			reason = REASON_LENGTH;
		end else if (temp_fail_s1) begin
			reason = REASON_TEMP;
		end else if (gc_fail) begin
			reason = REASON_CONTENT;
		end else begin
			reason = REASON_NONE;
		end
	end

	// stage 2: verdict and saturated report fields
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			res_s2.passed        <= (reason == REASON_NONE);
			res_s2.fail_reason   <= reason;
			res_s2.melt_temp     <= (32'(temp_s1) > 32'd16383) ? 14'h3FFF : 14'(temp_s1);
			res_s2.gc_total      <= (32'(gc_s1) > 32'd4095) ? 12'hFFF : 12'(gc_s1);
			res_s2.primer_length <= (32'(len_s1) > 32'd4095) ? 12'hFFF : 12'(len_s1);
		end
	end

	`DPV_ASSERT_SAME(a_back_verdict, v_s2, res_s2.passed == (res_s2.fail_reason == REASON_NONE), "verdict and reason disagree")
	`DPV_ASSERT_NEXT(a_back_hold, v_s1 && !adv_s2, v_s1, "stage 1 lost an item while stalled")
	`DPV_ASSERT_NEXT(a_back_load, in_pop, v_s1, "popped record did not enter stage 1")

endmodule

// ----- rtl/core/dna_primer_validator.sv -----
// Channel   Dir  Handshake                  Carries
// input     in   push / full                symbol, last_symbol
// result    out  pop / empty                passed, fail_reason, melt_temp,
//                                           gc_total, primer_length
// config    in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One character is taken per cycle unless full; counters update in one step,
// so full rises only when both entries of the record queue are occupied.
// A record leaves the record queue, passes through the check pipeline (bounds
// and cross products, then the verdict) and lands in the result queue.
// Reset is asynchronous and clears counters, queue pointers, valid flags and
// configuration to 0; the data registers are not reset.
// A stalled result side backs up through the pipeline into the record queue;
// once that is full, full holds back every character until a record leaves.
module dna_primer_validator #(
	parameter int COUNT_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  symbol,
	input  logic        last_symbol,
	input  logic        pop,
	output logic        empty,
	output logic        passed,
	output logic [2:0]  fail_reason,
	output logic [13:0] melt_temp,
	output logic [11:0] gc_total,
	output logic [11:0] primer_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import dpv_pkg::*;

	localparam int RW = 3 * COUNT_BITS + 1;

	dpv_cfg_t    cfg_q;
	logic        rec_push, rec_full, rec_empty, rec_pop;
	logic [RW-1:0] rec_wdata, rec_rdata;
	logic        res_push, res_full;
	dpv_result_t res_wdata, res_rdata;
	logic        full_unused;

	// configuration: always ready, index outside the map is dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LENGTH_MIN:  cfg_q.length_min       <= cfg_data[11:0];
				REG_LENGTH_MAX:  cfg_q.length_max       <= cfg_data[11:0];
				REG_TEMP_MIN:    cfg_q.temp_min         <= cfg_data[13:0];
				REG_TEMP_MAX:    cfg_q.temp_max         <= cfg_data[13:0];
				REG_CONTENT_MIN: cfg_q.content_min      <= cfg_data;
				REG_CONTENT_MAX: cfg_q.content_max      <= cfg_data;
				REG_GC_START:    cfg_q.require_gc_start <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// front end: counts characters and emits one record per primer
	dpv_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.symbol      (symbol),
		.last_symbol (last_symbol),
		.full        (rec_full),
		.rec_push    (rec_push),
		.rec_data    (rec_wdata)
	);

	assign full = rec_full;

	// record queue decouples counting from checking
	dpv_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_rec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_wdata),
		.full   (rec_full),
		.pop    (rec_pop),
		.rdata  (rec_rdata),
		.empty  (rec_empty)
	);

	// back end: two-stage check pipeline
	dpv_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_empty (rec_empty),
		.in_data  (rec_rdata),
		.in_pop   (rec_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_data (res_wdata)
	);

	// result queue parts the pipeline from the consumer
	dpv_fifo #(.WIDTH($bits(dpv_result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign full_unused   = 1'b0;
	assign passed        = res_rdata.passed | full_unused;
	assign fail_reason   = res_rdata.fail_reason;
	assign melt_temp     = res_rdata.melt_temp;
	assign gc_total      = res_rdata.gc_total;
	assign primer_length = res_rdata.primer_length;

endmodule
